@@ rtl/i2a_pkg.sv @@
// Shared types, constants and the digit-to-character function of the ASCII digit converter.
package i2a_pkg;

  localparam int unsigned ValueWidth = 64;
  localparam int unsigned CharWidth  = 7;
  localparam int unsigned NibWidth   = 4;
  localparam int unsigned NumDigits  = 20;
  localparam int unsigned DigitBits  = NumDigits * NibWidth;
  localparam int unsigned RemWidth   = 5;
  localparam int unsigned StepWidth  = 6;

  localparam logic [RemWidth-1:0]  DigitsDec = 5'd20;
  localparam logic [RemWidth-1:0]  DigitsHex = 5'd16;
  localparam logic [StepWidth-1:0] LastStep  = 6'd63;

  localparam logic [CharWidth-1:0] AsciiZero   = 7'd48;
  localparam logic [CharWidth-1:0] AsciiLowerA = 7'd97;
  localparam logic [CharWidth-1:0] DecBase     = 7'd10;
  localparam logic [NibWidth-1:0]  MaxDecDigit = 4'd9;

  localparam logic OpDec = 1'b0;
  localparam logic OpHex = 1'b1;

  typedef struct packed {
    logic load;
    logic hex;
    logic dabble;
    logic shift;
  } i2a_cmd_t;

  typedef struct packed {
    logic conv_last;
    logic top_zero;
    logic one_left;
  } i2a_sts_t;

  function automatic logic [CharWidth-1:0] i2a_ascii(input logic [NibWidth-1:0] d);
    logic [CharWidth-1:0] wide;
    wide = {3'b000, d};
    if (d > MaxDecDigit) begin
      return AsciiLowerA + wide - DecBase;
    end
    return AsciiZero + wide;
  endfunction

endpackage

@@ rtl/i2a_ctrl.sv @@
// Controller state machine that sequences conversion, zero skipping and digit output.
module i2a_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              op_i,
  input  logic              out_ready_i,
  input  i2a_pkg::i2a_sts_t sts_i,
  output i2a_pkg::i2a_cmd_t cmd_o,
  output logic              in_ready_o,
  output logic              out_valid_o
);
  import i2a_pkg::*;

  typedef enum logic [1:0] {
    StIdle,
    StConv,
    StSkip,
    StEmit
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.hex = op_i;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = (op_i == OpHex) ? StSkip : StConv;
        end
      end
      StConv: begin
        cmd_o.dabble = 1'b1;
        if (sts_i.conv_last) begin
          state_d = StSkip;
        end
      end
      StSkip: begin
        if (sts_i.top_zero && !sts_i.one_left) begin
          cmd_o.shift = 1'b1;
        end else begin
          state_d = StEmit;
        end
      end
      StEmit: begin
        if (out_ready_i) begin
          if (sts_i.one_left) begin
            state_d = StIdle;
          end else begin
            cmd_o.shift = 1'b1;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = (state_q == StEmit);

endmodule

@@ rtl/i2a_dpath.sv @@
// Datapath with the shift-and-add-three converter, digit shift register and counters.
module i2a_dpath (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  i2a_pkg::i2a_cmd_t                  cmd_i,
  input  logic [i2a_pkg::ValueWidth-1:0]     value_i,
  output i2a_pkg::i2a_sts_t                  sts_o,
  output logic [i2a_pkg::CharWidth-1:0]      digit_char_o
);
  import i2a_pkg::*;

  logic [DigitBits-1:0]  bcd_q, bcd_d, adj;
  logic [ValueWidth-1:0] bin_q, bin_d;
  logic [StepWidth-1:0]  step_q, step_d;
  logic [RemWidth-1:0]   rem_q, rem_d;

  always_comb begin
    for (int i = 0; i < NumDigits; i++) begin
      if (bcd_q[i*NibWidth +: NibWidth] >= 4'd5) begin
        adj[i*NibWidth +: NibWidth] = bcd_q[i*NibWidth +: NibWidth] + 4'd3;
      end else begin
        adj[i*NibWidth +: NibWidth] = bcd_q[i*NibWidth +: NibWidth];
      end
    end
  end

  always_comb begin
    bcd_d  = bcd_q;
    bin_d  = bin_q;
    step_d = step_q;
    rem_d  = rem_q;
    if (cmd_i.load) begin
      bin_d  = value_i;
      step_d = '0;
      if (cmd_i.hex == OpHex) begin
        bcd_d = {value_i, {(DigitBits-ValueWidth){1'b0}}};
        rem_d = DigitsHex;
      end else begin
        bcd_d = '0;
        rem_d = DigitsDec;
      end
    end else if (cmd_i.dabble) begin
      bcd_d  = {adj[DigitBits-2:0], bin_q[ValueWidth-1]};
      bin_d  = {bin_q[ValueWidth-2:0], 1'b0};
      step_d = step_q + 1'b1;
    end else if (cmd_i.shift) begin
      bcd_d = {bcd_q[DigitBits-NibWidth-1:0], {NibWidth{1'b0}}};
      rem_d = rem_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      rem_q  <= '0;
    end else begin
      step_q <= step_d;
      rem_q  <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bcd_q <= bcd_d;
    bin_q <= bin_d;
  end

  assign sts_o.conv_last = (step_q == LastStep);
  assign sts_o.top_zero  = (bcd_q[DigitBits-1 -: NibWidth] == '0);
  assign sts_o.one_left  = (rem_q == 5'd1);
  assign digit_char_o    = i2a_ascii(bcd_q[DigitBits-1 -: NibWidth]);

endmodule

@@ rtl/integer_to_ascii_digits.sv @@
// Top level of the unsigned 64-bit to decimal or hexadecimal ASCII digit converter.
// The block takes one number at a time and returns its digit characters, most significant
// first and without leading zeros, with last set on the final digit; zero gives a single '0'.
// A decimal item first runs through the shift-and-add-three loop, one input bit per cycle;
// then leading zeros are dropped, and the digits are offered as the output accepts them.
// The dropped zeros and the digits always make twenty for a decimal item. A hexadecimal
// item skips the conversion loop; its dropped zeros and digits always make sixteen.
// The next item is taken in the cycle after the last digit has been accepted.
module integer_to_ascii_digits (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic                               op_i,
  input  logic [i2a_pkg::ValueWidth-1:0]     value_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [i2a_pkg::CharWidth-1:0]      digit_char_o,
  output logic                               last_o
);
  import i2a_pkg::*;

  i2a_cmd_t cmd;
  i2a_sts_t sts;

  i2a_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .op_i        (op_i),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o)
  );

  i2a_dpath u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .value_i      (value_i),
    .sts_o        (sts),
    .digit_char_o (digit_char_o)
  );

  assign last_o = sts.one_left;

endmodule

@@ rtl/i2a_checker.sv @@
// Port-level assertions for the ASCII digit converter, bound to the top level.
module i2a_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_valid_i,
  input logic                               in_ready_o,
  input logic                               op_i,
  input logic [i2a_pkg::ValueWidth-1:0]     value_i,
  input logic                               out_valid_o,
  input logic                               out_ready_i,
  input logic [i2a_pkg::CharWidth-1:0]      digit_char_o,
  input logic                               last_o
);
  import i2a_pkg::*;

  logic unused_in;
  assign unused_in = op_i ^ (^value_i);

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("Input ready while a digit is being offered.");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("Input ready straight after an item was accepted.");

  a_idle_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && last_o) |=> (!out_valid_o && in_ready_o))
    else $error("Block not idle after the last digit of an item.");

  a_char_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((digit_char_o >= AsciiZero && digit_char_o <= 7'd57) ||
                     (digit_char_o >= AsciiLowerA && digit_char_o <= 7'd102)))
    else $error("Digit character outside the digit ranges.");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(digit_char_o) && $stable(last_o)))
    else $error("Stalled output item changed.");

endmodule

bind integer_to_ascii_digits i2a_checker u_i2a_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .op_i         (op_i),
  .value_i      (value_i),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .digit_char_o (digit_char_o),
  .last_o       (last_o)
);
